// File: sv/egsp_pkg.sv
// Shared types, constants and codes for the epoch-guarded slot probe block.
// Used by egsp_ctrl, egsp_dp and epoch_guarded_slot_probe_top; no dependencies.
`default_nettype none

package egsp_pkg;

  localparam int unsigned SLOTS_PER_REGION_DEF = 1024;
  localparam int unsigned REGION_COUNT_DEF     = 3;

  localparam int COUNT_W   = 11;
  localparam int POS_W     = 10;
  localparam int EPOCH_W   = 64;
  localparam int FLAG_W    = 8;
  localparam int REGION_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam int IN_DATA_W  = 224;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 80;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_PRIME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CACHE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACKUP = 2'd2;

  localparam logic [REGION_W-1:0] REGION_PRIME  = 2'd0;
  localparam logic [REGION_W-1:0] REGION_CACHE  = 2'd1;
  localparam logic [REGION_W-1:0] REGION_BACKUP = 2'd2;

  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_PROBE = 1'b1;

  localparam int FLAG_VALID_BIT = 0;
  localparam int FLAG_TOMB_BIT  = 1;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_NO_SLOTS,
    STATUS_FULL,
    STATUS_BAD_HOME
  } egsp_status_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] guard;
    logic [EPOCH_W-1:0] visible;
    logic [EPOCH_W-1:0] digest;
    logic [FLAG_W-1:0]  flags;
  } egsp_slot_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_PROBE,
    ST_FINISH
  } egsp_state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic store;
    logic check;
    logic run;
    logic emit;
  } egsp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_probe;
    logic check_err;
    logic walk_end;
    logic out_free;
  } egsp_stat_t;

endpackage

`default_nettype wire

// File: sv/egsp_ctrl.sv
// Controller state machine: clearing pass, item intake, store/probe sequencing, result hand-off.
// Depends on egsp_pkg; drives egsp_dp through command/status structs.
`default_nettype none

module egsp_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire egsp_pkg::egsp_stat_t    stat,
  output egsp_pkg::egsp_cmd_t          cmd
);
  import egsp_pkg::*;

  egsp_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (!stat.is_probe || stat.check_err) state_next = ST_FINISH;
        else state_next = ST_PROBE;
      end
      ST_PROBE: begin
        if (stat.walk_end) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DECODE: begin
        cmd.store = !stat.is_probe;
        cmd.check = stat.is_probe;
      end
      ST_PROBE:  cmd.run  = 1'b1;
      ST_FINISH: cmd.emit = stat.out_free;
      default: ;
    endcase
  end

  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free) else $error("result emitted over a pending one");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd)) else $error("more than one datapath command");

  a_walk_to_finish: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) && stat.walk_end |=> state == ST_FINISH)
    else $error("walk end did not reach finish");

endmodule

`default_nettype wire

// File: sv/egsp_dp.sv
// Datapath: count registers, slot memory with clearing pass, probe walk and result register.
// Depends on egsp_pkg; sequenced by egsp_ctrl.
`default_nettype none

module egsp_dp #(
  parameter int unsigned SLOTS_PER_REGION = egsp_pkg::SLOTS_PER_REGION_DEF,
  parameter int unsigned REGION_COUNT     = egsp_pkg::REGION_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire egsp_pkg::egsp_cmd_t             cmd,
  output egsp_pkg::egsp_stat_t                 stat,
  input  wire logic                            cfg_write,
  input  wire logic [egsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [egsp_pkg::COUNT_W-1:0]    cfg_data,
  input  wire logic [egsp_pkg::IN_DATA_W-1:0]  in_data,
  input  wire logic [egsp_pkg::IN_USER_W-1:0]  in_user,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [egsp_pkg::OUT_DATA_W-1:0]      out_data
);
  import egsp_pkg::*;

  localparam int unsigned TOTAL = SLOTS_PER_REGION * REGION_COUNT;
  localparam int AW = $clog2(TOTAL);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TOTAL - 1);

  logic [COUNT_W-1:0] prime_count, cache_count, bak_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_count <= COUNT_RESET;
      cache_count <= COUNT_RESET;
      bak_count   <= COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PRIME:  prime_count <= cfg_data;
        REG_CACHE:  cache_count <= cfg_data;
        REG_BACKUP: bak_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                mode_q;
  logic [REGION_W-1:0] region_q;
  logic [POS_W-1:0]    spos_q, home_q;
  egsp_slot_t          item_slot;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q            <= in_user[0];
      region_q          <= in_user[2:1];
      spos_q            <= in_data[9:0];
      home_q            <= in_data[19:10];
      item_slot.digest  <= in_data[83:20];
      item_slot.guard   <= in_data[147:84];
      item_slot.visible <= in_data[211:148];
      item_slot.flags   <= in_data[219:212];
    end
  end

  logic [COUNT_W-1:0] raw_count, count;
  egsp_status_t       check_code;

  always_comb begin
    case (region_q)
      REGION_PRIME:  raw_count = prime_count;
      REGION_CACHE:  raw_count = cache_count;
      REGION_BACKUP: raw_count = bak_count;
      default:       raw_count = '0;
    endcase
    if (32'(region_q) >= REGION_COUNT) raw_count = '0;
    count = (32'(raw_count) > SLOTS_PER_REGION) ? COUNT_W'(SLOTS_PER_REGION) : raw_count;
    if (count == '0) check_code = STATUS_NO_SLOTS;
    else if ({1'b0, home_q} >= count) check_code = STATUS_BAD_HOME;
    else check_code = STATUS_OK;
  end

  // slot memory and clearing pass
  egsp_slot_t mem [TOTAL];
  egsp_slot_t rd_data;
  logic [AW-1:0] clr_addr, store_addr, raddr, waddr;
  logic          store_ok, mem_we;
  egsp_slot_t    wdata;

  logic [COUNT_W-1:0] issue_pos, issue_cnt, issue_pos_inc, rd_pos;
  logic               issue_ok, rd_valid;

  assign store_addr = AW'(32'(region_q) * 32'(SLOTS_PER_REGION) + 32'(spos_q));
  assign store_ok   = (32'(region_q) < REGION_COUNT) && (32'(spos_q) < SLOTS_PER_REGION);
  assign raddr      = AW'(32'(region_q) * 32'(SLOTS_PER_REGION) + 32'(issue_pos));
  assign mem_we     = cmd.clear || (cmd.store && store_ok);
  assign waddr      = cmd.clear ? clr_addr : store_addr;
  assign wdata      = cmd.clear ? '0 : item_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rd_data <= mem[raddr];
  end

  // probe walk: one read issued per cycle, evaluated from the registered read data
  logic torn, f_valid, f_tomb, hit_now, tomb_now, empty_now;

  assign issue_ok      = issue_cnt != count;
  assign issue_pos_inc = (issue_pos + 1'b1 >= count) ? '0 : issue_pos + 1'b1;

  assign torn      = rd_data.guard != rd_data.visible;
  assign f_valid   = rd_data.flags[FLAG_VALID_BIT];
  assign f_tomb    = rd_data.flags[FLAG_TOMB_BIT];
  assign hit_now   = !torn && f_valid && (rd_data.digest == item_slot.digest);
  assign tomb_now  = !torn && f_valid && f_tomb;
  assign empty_now = !torn && (rd_data.guard == '0) && (rd_data.digest == '0)
                     && (rd_data.flags == '0);

  egsp_status_t       res_err;
  logic               res_hit, res_tomb, res_cand_ok;
  logic [COUNT_W-1:0] res_cand_pos;
  logic [EPOCH_W-1:0] res_guard;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.run && issue_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_err      <= STATUS_OK;
      res_hit      <= 1'b0;
      res_tomb     <= 1'b0;
      res_cand_ok  <= 1'b0;
      res_cand_pos <= '0;
      res_guard    <= '0;
    end else if (cmd.check) begin
      res_err   <= check_code;
      issue_pos <= {1'b0, home_q};
      issue_cnt <= '0;
    end else if (cmd.run) begin
      if (issue_ok) begin
        issue_pos <= issue_pos_inc;
        issue_cnt <= issue_cnt + 1'b1;
        rd_pos    <= issue_pos;
      end
      if (rd_valid) begin
        if (hit_now) begin
          res_hit      <= 1'b1;
          res_tomb     <= f_tomb;
          res_cand_ok  <= 1'b1;
          res_cand_pos <= rd_pos;
          res_guard    <= rd_data.guard;
        end else if ((tomb_now || empty_now) && !res_cand_ok) begin
          res_cand_ok  <= 1'b1;
          res_cand_pos <= rd_pos;
          res_guard    <= rd_data.guard;
        end
      end
    end
  end

  // result register
  egsp_status_t       out_status, final_status;
  logic               out_hit, out_tomb, out_cand_ok;
  logic [POS_W-1:0]   out_pos;
  logic [EPOCH_W-1:0] out_guard;

  always_comb begin
    if (res_err != STATUS_OK) final_status = res_err;
    else if (mode_q == MODE_PROBE && !res_cand_ok) final_status = STATUS_FULL;
    else final_status = STATUS_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status  <= final_status;
      out_hit     <= res_hit;
      out_tomb    <= res_tomb;
      out_cand_ok <= res_cand_ok;
      out_pos     <= res_cand_pos[POS_W-1:0];
      out_guard   <= res_guard;
    end
  end

  assign out_data = {1'b0, out_guard, out_pos, out_cand_ok, out_tomb, out_hit, out_status};

  assign stat.clear_last = clr_addr == LAST_ADDR;
  assign stat.is_probe   = mode_q == MODE_PROBE;
  assign stat.check_err  = check_code != STATUS_OK;
  assign stat.walk_end   = rd_valid && (hit_now || empty_now || !issue_ok);
  assign stat.out_free   = !out_valid || out_ready;

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status != STATUS_OK) |->
      !out_hit && !out_cand_ok && (out_pos == '0) && (out_guard == '0))
    else $error("error result carries candidate fields");

  a_hit_has_cand: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_hit |-> out_cand_ok) else $error("hit without candidate");

  a_read_from_run: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> $past(cmd.run)) else $error("read valid outside walk");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.run |-> issue_cnt <= count) else $error("walk read past region count");

  a_rd_pos_range: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> rd_pos < count) else $error("walk position out of region");

endmodule

`default_nettype wire

// File: sv/epoch_guarded_slot_probe_top.sv
// Flow: a store item, or a probe that fails its region check, goes through the decode and
// finish states before its result is registered; a probe reads one slot per cycle from the
// slot memory read port, each evaluated from the registered read data, then goes to finish.
// Intake: a new item is taken only after the previous result is emitted, and finish waits
// while a pending result is not yet taken. Reset: synchronous; a clearing pass zeroes all
// REGION_COUNT*SLOTS_PER_REGION slots with s_axis_tready low; slot counts reset to 1024.
`default_nettype none

module epoch_guarded_slot_probe_top #(
  parameter int unsigned SLOTS_PER_REGION = egsp_pkg::SLOTS_PER_REGION_DEF,
  parameter int unsigned REGION_COUNT     = egsp_pkg::REGION_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [egsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [egsp_pkg::COUNT_W-1:0]    cfg_data,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // slot_position, home_position, key_digest, guard_value, visible_value, slot_flags, pad
  input  wire logic [egsp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // mode, region
  input  wire logic [egsp_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // status, hit, hit_is_tombstone, candidate_ok, candidate_position, candidate_guard, pad
  output logic [egsp_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
  import egsp_pkg::*;

  egsp_cmd_t  cmd;
  egsp_stat_t stat;

  egsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  egsp_dp #(
    .SLOTS_PER_REGION (SLOTS_PER_REGION),
    .REGION_COUNT     (REGION_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// File: tb/tb_epoch_guarded_slot_probe_top.sv
// Self-checking bench for epoch_guarded_slot_probe_top: a directed table then random
// store/probe traffic, scored against an in-bench slot-store predictor.
// Depends on egsp_pkg (sv/egsp_pkg.sv) and the RTL top level.
`timescale 1ns / 1ps

module tb_epoch_guarded_slot_probe_top;
  import egsp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;
  localparam logic [REGION_W-1:0]  REGION_NONE = 2'd3;
  localparam int LONG_STALL  = 400;
  localparam int PER_SETTING = 146;
  localparam int SETTINGS_N  = 6;
  localparam int PRINT_MAX   = 30;

  localparam logic [EPOCH_W-1:0] KEY_A = 64'h0123_4567_89ab_cdef;
  localparam logic [EPOCH_W-1:0] KEY_B = 64'hfedc_ba98_7654_3210;
  localparam logic [EPOCH_W-1:0] KEY_C = 64'h8000_0000_0000_0001;
  localparam logic [EPOCH_W-1:0] KEY_D = 64'h5a5a_a5a5_0f0f_f0f0;
  localparam logic [EPOCH_W-1:0] EP_A  = 64'h0000_0000_0000_0007;
  localparam logic [EPOCH_W-1:0] EP_B  = 64'h1111_2222_3333_4444;
  localparam logic [EPOCH_W-1:0] EP_C  = 64'h1111_2222_3333_4445;
  localparam logic [EPOCH_W-1:0] EP_D  = 64'hc0de_0000_0000_beef;
  localparam logic [FLAG_W-1:0]  FL_LIVE = 8'h01;
  localparam logic [FLAG_W-1:0]  FL_TOMB = 8'h03;

  typedef struct packed {
    logic               mode;
    logic [REGION_W-1:0] region;
    logic [POS_W-1:0]   spos;
    logic [POS_W-1:0]   home;
    logic [EPOCH_W-1:0] key;
    logic [EPOCH_W-1:0] guard;
    logic [EPOCH_W-1:0] visible;
    logic [FLAG_W-1:0]  flags;
  } slot_req_t;

  typedef struct packed {
    egsp_status_t       status;
    logic               hit;
    logic               tomb;
    logic               cand_ok;
    logic [POS_W-1:0]   cand_pos;
    logic [EPOCH_W-1:0] cand_guard;
  } slot_resp_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [COUNT_W-1:0]   cfg_val;
    slot_req_t            req;
    bit                   typed;
    slot_resp_t           want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [COUNT_W-1:0]    cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // slot_position, home_position, key_digest, guard_value, visible_value, slot_flags, pad
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // mode, region
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // status, hit, hit_is_tombstone, candidate_ok, candidate_position, candidate_guard, pad
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  logic [EPOCH_W-1:0] sh_guard   [SLOTS_PER_REGION_DEF*REGION_COUNT_DEF];
  logic [EPOCH_W-1:0] sh_visible [SLOTS_PER_REGION_DEF*REGION_COUNT_DEF];
  logic [EPOCH_W-1:0] sh_digest  [SLOTS_PER_REGION_DEF*REGION_COUNT_DEF];
  logic [FLAG_W-1:0]  sh_flags   [SLOTS_PER_REGION_DEF*REGION_COUNT_DEF];
  logic [COUNT_W-1:0] sh_count   [REGION_COUNT_DEF];

  slot_resp_t   awaited_resp [$];
  logic [EPOCH_W-1:0] key_pool [8];
  int unsigned  win_base [REGION_COUNT_DEF];
  int unsigned  setting_counts [SETTINGS_N][3] = '{
    '{16, 5, 1024}, '{1024, 1, 64}, '{0, 1024, 8},
    '{2047, 3, 12}, '{7, 1024, 0}, '{1, 2, 1024}
  };

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_ask = 0;
  int stall_seen = 0;
  int stall_left = 0;
  int mismatches = 0;
  int n_store = 0;
  int n_probe = 0;
  int n_hit = 0;
  int n_full = 0;
  int n_err = 0;

  epoch_guarded_slot_probe_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [EPOCH_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned slots_in(logic [REGION_W-1:0] region);
    int unsigned n;
    if (region >= REGION_COUNT_DEF) return 0;
    n = 32'(sh_count[region]);
    return (n > SLOTS_PER_REGION_DEF) ? SLOTS_PER_REGION_DEF : n;
  endfunction

  function automatic int unsigned window_span(int unsigned lim);
    return (lim == 0) ? 1 : ((lim < 32) ? lim : 32);
  endfunction

  // Apply one item to the shadow slot store and return the result it should produce.
  function automatic slot_resp_t resolve_slot_op(slot_req_t r);
    slot_resp_t  o;
    int unsigned lim, base, pos, a, s;
    bit          done;
    o = '0;
    if (r.mode == MODE_STORE) begin
      if (r.region < REGION_COUNT_DEF) begin
        a = r.region * SLOTS_PER_REGION_DEF + r.spos;
        sh_guard[a]   = r.guard;
        sh_visible[a] = r.visible;
        sh_digest[a]  = r.key;
        sh_flags[a]   = r.flags;
      end
      return o;
    end
    lim = slots_in(r.region);
    if (lim == 0) begin
      o.status = STATUS_NO_SLOTS;
    end else if (r.home >= lim) begin
      o.status = STATUS_BAD_HOME;
    end else begin
      base = r.region * SLOTS_PER_REGION_DEF;
      pos  = r.home;
      done = 1'b0;
      for (s = 0; s < lim && !done; s++) begin
        a = base + pos;
        if (sh_guard[a] == sh_visible[a]) begin
          if (sh_flags[a][FLAG_VALID_BIT] && sh_digest[a] == r.key) begin
            o.hit        = 1'b1;
            o.tomb       = sh_flags[a][FLAG_TOMB_BIT];
            o.cand_ok    = 1'b1;
            o.cand_pos   = pos[POS_W-1:0];
            o.cand_guard = sh_guard[a];
            done         = 1'b1;
          end else if (sh_flags[a][FLAG_VALID_BIT] && sh_flags[a][FLAG_TOMB_BIT]) begin
            if (!o.cand_ok) begin
              o.cand_ok    = 1'b1;
              o.cand_pos   = pos[POS_W-1:0];
              o.cand_guard = sh_guard[a];
            end
          end else if (sh_guard[a] == '0 && sh_digest[a] == '0 && sh_flags[a] == '0) begin
            if (!o.cand_ok) begin
              o.cand_ok    = 1'b1;
              o.cand_pos   = pos[POS_W-1:0];
              o.cand_guard = '0;
            end
            done = 1'b1;
          end
        end
        pos = (pos + 1 >= lim) ? 0 : pos + 1;
      end
      if (!o.cand_ok) o.status = STATUS_FULL;
    end
    return o;
  endfunction

  function automatic slot_req_t draw_item();
    slot_req_t   r;
    int unsigned sel, kind, lim, where;
    logic [FLAG_W-1:0] junk;
    r      = '0;
    junk   = FLAG_W'($urandom_range(255));
    sel    = $urandom_range(99);
    r.region = REGION_W'($urandom_range(2));
    lim    = slots_in(r.region);
    where  = win_base[r.region] + $urandom_range(window_span(lim) - 1);
    r.key  = ($urandom_range(9) < 8) ? key_pool[$urandom_range(7)] : rand64();
    if (sel >= 94) begin
      r.mode = 1'($urandom_range(1));
      if ($urandom_range(1)) r.region = REGION_NONE;
      r.home    = POS_W'($urandom_range(1023));
      r.spos    = POS_W'($urandom_range(1023));
      r.guard   = rand64();
      r.visible = $urandom_range(1) ? r.guard : rand64();
      r.flags   = junk;
    end else if (sel < 45) begin
      r.mode    = MODE_STORE;
      r.spos    = POS_W'(($urandom_range(9) == 0) ? $urandom_range(1023) : where);
      r.home    = POS_W'($urandom_range(1023));
      r.guard   = rand64();
      r.visible = r.guard;
      kind      = $urandom_range(9);
      if (kind < 5) begin
        r.flags = {junk[7:2], 2'b01};
      end else if (kind < 7) begin
        r.flags = {junk[7:2], 2'b11};
      end else if (kind == 7) begin
        r.visible = r.guard ^ (64'd1 << $urandom_range(63));
        r.flags   = junk;
      end else if (kind == 8) begin
        r.guard   = '0;
        r.visible = '0;
        r.key     = '0;
        r.flags   = '0;
      end else begin
        if ($urandom_range(1)) r.guard = '0;
        r.visible = r.guard;
        r.flags   = junk;
      end
    end else begin
      r.mode    = MODE_PROBE;
      r.home    = POS_W'(where);
      r.spos    = POS_W'($urandom_range(1023));
      r.guard   = rand64();
      r.visible = rand64();
      r.flags   = junk;
    end
    return r;
  endfunction

  function automatic dir_row_t item_row(logic mode, logic [REGION_W-1:0] region,
                                        logic [POS_W-1:0] pos, logic [EPOCH_W-1:0] key,
                                        logic [EPOCH_W-1:0] guard,
                                        logic [EPOCH_W-1:0] visible,
                                        logic [FLAG_W-1:0] flags);
    dir_row_t row;
    row.is_cfg      = 1'b0;
    row.cfg_idx     = '0;
    row.cfg_val     = '0;
    row.req.mode    = mode;
    row.req.region  = region;
    row.req.spos    = pos;
    row.req.home    = pos;
    row.req.key     = key;
    row.req.guard   = guard;
    row.req.visible = visible;
    row.req.flags   = flags;
    row.typed       = 1'b0;
    row.want        = '0;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
    dir_row_t row;
    row = item_row(MODE_STORE, REGION_PRIME, '0, '0, '0, '0, '0);
    row.is_cfg  = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = val;
    return row;
  endfunction

  function automatic dir_row_t pinned(dir_row_t row, egsp_status_t st, logic ok,
                                      logic [POS_W-1:0] pos);
    row.typed         = 1'b1;
    row.want.status   = st;
    row.want.cand_ok  = ok;
    row.want.cand_pos = pos;
    return row;
  endfunction

  task automatic report_mismatch(string what, logic [EPOCH_W-1:0] want,
                                 logic [EPOCH_W-1:0] got);
    mismatches++;
    if (mismatches <= PRINT_MAX)
      $display("mismatch %s: expected %h got %h at %0t", what, want, got, $time);
  endtask

  task automatic check_result(logic [OUT_DATA_W-1:0] d);
    slot_resp_t w;
    if (awaited_resp.size() == 0) begin
      report_mismatch("item with nothing expected", '0, d[EPOCH_W-1:0]);
      return;
    end
    w = awaited_resp.pop_front();
    if (d[1:0] != w.status)     report_mismatch("status", w.status, d[1:0]);
    if (d[2] != w.hit)          report_mismatch("hit", w.hit, d[2]);
    if (d[3] != w.tomb)         report_mismatch("hit_is_tombstone", w.tomb, d[3]);
    if (d[4] != w.cand_ok)      report_mismatch("candidate_ok", w.cand_ok, d[4]);
    if (d[14:5] != w.cand_pos)  report_mismatch("candidate_position", w.cand_pos, d[14:5]);
    if (d[78:15] != w.cand_guard)
      report_mismatch("candidate_guard", w.cand_guard, d[78:15]);
  endtask

  task automatic push_item(slot_req_t r, bit typed, slot_resp_t want);
    slot_resp_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, r.flags, r.visible, r.guard, r.key, r.home, r.spos};
    s_axis_tuser  <= {r.region, r.mode};
    do @(posedge clk); while (!s_axis_tready);
    got = resolve_slot_op(r);
    if (r.mode == MODE_STORE) begin
      n_store++;
    end else begin
      n_probe++;
      if (got.hit) n_hit++;
      if (got.status == STATUS_FULL) n_full++;
      else if (got.status != STATUS_OK) n_err++;
    end
    awaited_resp.push_back(typed ? want : got);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_resp.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx != REG_UNUSED) sh_count[idx] = val;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_seen != stall_ask) begin
      stall_seen = stall_ask;
      stall_left = LONG_STALL;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    dir_row_t    rows [$];
    slot_resp_t  blank;
    int unsigned a, p, i, k, lim;
    blank = '0;
    for (a = 0; a < SLOTS_PER_REGION_DEF * REGION_COUNT_DEF; a++) begin
      sh_guard[a]   = '0;
      sh_visible[a] = '0;
      sh_digest[a]  = '0;
      sh_flags[a]   = '0;
    end
    for (k = 0; k < REGION_COUNT_DEF; k++) sh_count[k] = COUNT_RESET;

    rows.push_back(pinned(item_row(MODE_PROBE, REGION_PRIME, 10'd0, '0, '0, '0, '0),
                          STATUS_OK, 1'b1, 10'd0));
    rows.push_back(pinned(item_row(MODE_PROBE, REGION_PRIME, 10'd1023, '1, '0, '0, '0),
                          STATUS_OK, 1'b1, 10'd1023));
    rows.push_back(pinned(item_row(MODE_PROBE, REGION_NONE, 10'd0, KEY_A, '0, '0, '0),
                          STATUS_NO_SLOTS, 1'b0, 10'd0));
    rows.push_back(pinned(item_row(MODE_STORE, REGION_PRIME, 10'd0, KEY_A, EP_A, EP_A,
                                   FL_LIVE), STATUS_OK, 1'b0, 10'd0));
    rows.push_back(pinned(item_row(MODE_STORE, REGION_NONE, 10'd5, KEY_B, EP_A, EP_A,
                                   FL_TOMB), STATUS_OK, 1'b0, 10'd0));
    rows.push_back(item_row(MODE_STORE, REGION_PRIME, 10'd1, KEY_B, EP_B, EP_C, FL_LIVE));
    rows.push_back(item_row(MODE_STORE, REGION_PRIME, 10'd2, KEY_C, EP_D, EP_D, FL_TOMB));
    rows.push_back(item_row(MODE_STORE, REGION_PRIME, 10'd3, KEY_B, '1, '1, FL_LIVE));
    rows.push_back(item_row(MODE_PROBE, REGION_PRIME, 10'd0, KEY_B, '0, '0, '0));
    rows.push_back(item_row(MODE_PROBE, REGION_PRIME, 10'd0, KEY_C, '0, '0, '0));
    rows.push_back(item_row(MODE_PROBE, REGION_PRIME, 10'd0, KEY_D, '0, '0, '0));
    rows.push_back(item_row(MODE_STORE, REGION_BACKUP, 10'd1023, '1, '1, '1, 8'hff));
    rows.push_back(item_row(MODE_PROBE, REGION_BACKUP, 10'd1023, '1, '0, '0, '0));
    rows.push_back(cfg_row(REG_PRIME, 11'd4));
    rows.push_back(cfg_row(REG_CACHE, 11'd0));
    rows.push_back(cfg_row(REG_BACKUP, 11'd2047));
    rows.push_back(pinned(item_row(MODE_PROBE, REGION_CACHE, 10'd0, KEY_A, '0, '0, '0),
                          STATUS_NO_SLOTS, 1'b0, 10'd0));
    rows.push_back(pinned(item_row(MODE_PROBE, REGION_PRIME, 10'd4, KEY_A, '0, '0, '0),
                          STATUS_BAD_HOME, 1'b0, 10'd0));
    rows.push_back(pinned(item_row(MODE_PROBE, REGION_PRIME, 10'd1023, KEY_A, '0, '0, '0),
                          STATUS_BAD_HOME, 1'b0, 10'd0));
    rows.push_back(item_row(MODE_STORE, REGION_PRIME, 10'd4, KEY_D, EP_A, EP_A, FL_LIVE));
    rows.push_back(item_row(MODE_PROBE, REGION_PRIME, 10'd3, KEY_D, '0, '0, '0));
    rows.push_back(item_row(MODE_STORE, REGION_PRIME, 10'd2, KEY_C, EP_D, EP_D, FL_LIVE));
    rows.push_back(pinned(item_row(MODE_PROBE, REGION_PRIME, 10'd0, KEY_D, '0, '0, '0),
                          STATUS_FULL, 1'b0, 10'd0));
    rows.push_back(item_row(MODE_PROBE, REGION_BACKUP, 10'd1023, '1, '0, '0, '0));
    rows.push_back(cfg_row(REG_PRIME, 11'd1));
    rows.push_back(item_row(MODE_PROBE, REGION_PRIME, 10'd0, KEY_A, '0, '0, '0));
    rows.push_back(cfg_row(REG_UNUSED, 11'd1024));
    rows.push_back(pinned(item_row(MODE_PROBE, REGION_PRIME, 10'd2, KEY_A, '0, '0, '0),
                          STATUS_BAD_HOME, 1'b0, 10'd0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (!s_axis_tready);

    send_idle_pct = 24;
    recv_idle_pct = 69;
    foreach (rows[r]) begin
      if (rows[r].is_cfg) begin
        wait_idle();
        write_reg(rows[r].cfg_idx, rows[r].cfg_val);
      end else begin
        push_item(rows[r].req, rows[r].typed, rows[r].want);
      end
    end

    for (p = 0; p < SETTINGS_N; p++) begin
      send_idle_pct = (p < 2) ? 24 : ((p < 4) ? 69 : 0);
      recv_idle_pct = (p < 2) ? 69 : ((p < 4) ? 24 : 0);
      wait_idle();
      write_reg(REG_PRIME, COUNT_W'(setting_counts[p][0]));
      write_reg(REG_CACHE, COUNT_W'(setting_counts[p][1]));
      write_reg(REG_BACKUP, COUNT_W'(setting_counts[p][2]));
      for (k = 0; k < 8; k++) key_pool[k] = rand64();
      for (k = 0; k < REGION_COUNT_DEF; k++) begin
        lim = slots_in(REGION_W'(k));
        win_base[k] = (lim == 0) ? 0 : $urandom_range(lim - window_span(lim));
      end
      for (i = 0; i < PER_SETTING; i++) begin
        if (p == 0 && i == 40) stall_ask++;
        if (p == 1 && i == 70) wait_idle();
        push_item(draw_item(), 1'b0, blank);
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (awaited_resp.size() != 0)
      report_mismatch("items never returned", awaited_resp.size(), '0);
    $display("covered %0d stores and %0d probes over %0d count settings plus directed rows",
             n_store, n_probe, SETTINGS_N);
    $display("probes gave %0d hits, %0d full walks, %0d error statuses; %0d mismatches",
             n_hit, n_full, n_err, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout with %0d items outstanding", awaited_resp.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
